/* rtl/plid_pkg.sv */
// Shared types and codes for the positional list with insert and delete.
// Used by plid_cell and positional_list_insert_delete; no dependencies.
package plid_pkg;

  localparam int CAPACITY_DEF   = 128;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int POS_W          = 8;
  localparam int GROUP_SIZE     = 16;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic             grab;
    logic [POS_W-1:0] idx;
  } cell_ctl_t;

endpackage

/* rtl/plid_cell.sv */
// One entry of the list chain: holds a word and trades it with its neighbors.
// Depends on plid_pkg for the broadcast control struct.
module plid_cell #(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = plid_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  plid_pkg::cell_ctl_t   ctl,
  input  logic [DATA_WIDTH-1:0] ins_data,
  input  logic [DATA_WIDTH-1:0] left,
  input  logic [DATA_WIDTH-1:0] right,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] tap
);

  logic hit;
  logic above;

  assign hit   = (32'(ctl.idx) == INDEX);
  assign above = (32'(ctl.idx) < INDEX);

  always_ff @(posedge clk) begin
    if (ctl.shift_up && hit) begin
      data <= ins_data;
    end else if (ctl.shift_up && above) begin
      data <= left;
    end else if (ctl.shift_down && (hit || above)) begin
      data <= right;
    end
    tap <= (ctl.grab && hit) ? data : '0;
  end

endmodule

/* rtl/positional_list_insert_delete.sv */
// Top level of the positional list: a chain of plid_cell entries, the fill
// counter, and a registered OR tree that collects the addressed word.
// Depends on plid_pkg and plid_cell.
//
//   channel   handshake          fields
//   command   start / busy       kind, position, value_in
//   result    done (strobe)      status, value_out, count, empty_res
//
// A command is taken in any cycle; busy stays low. All entries shift in the
// cycle a command is taken, so the list is ready for the next one at once.
// The result word passes through the cell tap register, the registered group
// OR stage, a combinational final OR and the output register.
// Reset clears the fill count and the result pipeline; entry contents are
// left as they are and are never read before being written.
// Results go out for one cycle each; the receiver cannot stall them.
module positional_list_insert_delete #(
  parameter int CAPACITY   = plid_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = plid_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [7:0]  position,
  input  logic [31:0] value_in,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] value_out,
  output logic [7:0]  count,
  output logic        empty_res
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > plid_pkg::POS_W) ? CW : plid_pkg::POS_W) + 1;
  localparam int GS = plid_pkg::GROUP_SIZE;
  localparam int NG = (CAPACITY + GS - 1) / GS;

  logic [CW-1:0] fill;
  logic [CW-1:0] fill_next;
  logic [1:0]    st_next;
  logic          accept;
  logic [PW-1:0] pos_x;
  logic [PW-1:0] fill_x;
  logic          pos_nz;
  logic          ins_ok;
  logic          del_ok;
  logic          rd_ok;
  logic          is_full;
  plid_pkg::cell_ctl_t ctl;

  logic                  s1_valid, s2_valid;
  logic [1:0]            s1_status, s2_status;
  logic [CW-1:0]         s1_fill, s2_fill;

  logic [DATA_WIDTH-1:0] ins_data;
  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_tap  [CAPACITY];
  logic [DATA_WIDTH-1:0] group_or  [NG];
  logic [DATA_WIDTH-1:0] final_or;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign pos_x    = PW'(position);
  assign fill_x   = PW'(fill);
  assign pos_nz   = (position != '0);
  assign is_full  = (fill == CW'(CAPACITY));
  assign ins_data = DATA_WIDTH'(value_in);

  always_comb begin
    ins_ok    = 1'b0;
    del_ok    = 1'b0;
    rd_ok     = 1'b0;
    st_next   = plid_pkg::ST_RANGE;
    fill_next = fill;
    unique case (kind)
      plid_pkg::OP_INSERT: begin
        if (pos_nz && (pos_x <= fill_x + PW'(1))) begin
          if (is_full) begin
            st_next = plid_pkg::ST_FULL;
          end else begin
            ins_ok    = 1'b1;
            st_next   = plid_pkg::ST_OK;
            fill_next = fill + CW'(1);
          end
        end
      end
      plid_pkg::OP_DELETE: begin
        if (pos_nz && (pos_x <= fill_x)) begin
          del_ok    = 1'b1;
          st_next   = plid_pkg::ST_OK;
          fill_next = fill - CW'(1);
        end
      end
      plid_pkg::OP_READ: begin
        if (pos_nz && (pos_x <= fill_x)) begin
          rd_ok   = 1'b1;
          st_next = plid_pkg::ST_OK;
        end
      end
      default: begin
        st_next = plid_pkg::ST_RANGE;
      end
    endcase
  end

  always_comb begin
    ctl.shift_up   = accept && ins_ok;
    ctl.shift_down = accept && del_ok;
    ctl.grab       = accept && (del_ok || rd_ok);
    ctl.idx        = position - plid_pkg::POS_W'(1);
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w;
      logic [DATA_WIDTH-1:0] right_w;
      if (i == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = cell_data[i+1];
      end
      plid_cell #(
        .INDEX      (i),
        .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .ins_data (ins_data),
        .left     (left_w),
        .right    (right_w),
        .data     (cell_data[i]),
        .tap      (cell_tap[i])
      );
    end

    for (i = 0; i < NG; i++) begin : g_group
      logic [DATA_WIDTH-1:0] acc;
      always_comb begin
        acc = '0;
        for (int k = 0; k < GS; k++) begin
          if (i * GS + k < CAPACITY) begin
            acc = acc | cell_tap[i * GS + k];
          end
        end
      end
      always_ff @(posedge clk) begin
        group_or[i] <= acc;
      end
    end
  endgenerate

  always_comb begin
    final_or = '0;
    for (int g = 0; g < NG; g++) begin
      final_or = final_or | group_or[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      if (accept) begin
        fill <= fill_next;
      end
      s1_valid <= accept;
      s2_valid <= s1_valid;
      done     <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_status <= st_next;
    s1_fill   <= fill_next;
    s2_status <= s1_status;
    s2_fill   <= s1_fill;
    status    <= s2_status;
    count     <= 8'(s2_fill);
    empty_res <= (s2_fill == '0);
    value_out <= 32'(final_or);
  end

  assert property (@(posedge clk) disable iff (rst) fill <= CW'(CAPACITY))
    else $error("fill count exceeds capacity");

  assert property (@(posedge clk) disable iff (rst)
    accept |=> ##2 done)
    else $error("result missing three cycles after a command");

  assert property (@(posedge clk) disable iff (rst)
    done && (status != plid_pkg::ST_OK) |-> (value_out == '0))
    else $error("nonzero word on a failed operation");

  assert property (@(posedge clk) disable iff (rst)
    done && (status == plid_pkg::ST_FULL) |-> !empty_res)
    else $error("full status reported on an empty list");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for positional_list_insert_delete: a directed part and bursty random
// traffic that fills and drains the list, checked against a list model in a scoreboard class.
// Depends on plid_pkg and the RTL of positional_list_insert_delete.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = plid_pkg::CAPACITY_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] value;
    logic [7:0]  count;
    logic        empty;
  } list_result_t;

  class list_tracker;
    logic [31:0]  entries [CAP];
    int           fill_len;
    int           error_count;
    list_result_t expected_q [$];

    function new();
      fill_len = 0;
      error_count = 0;
    endfunction

    function void note_command(logic [1:0] k, logic [7:0] p, logic [31:0] v);
      list_result_t r;
      int pi;
      pi = p;
      r.status = plid_pkg::ST_RANGE;
      r.value = '0;
      case (k)
        plid_pkg::OP_INSERT: begin
          if (pi >= 1 && pi <= fill_len + 1) begin
            if (fill_len >= CAP) begin
              r.status = plid_pkg::ST_FULL;
            end else begin
              for (int j = fill_len; j > pi - 1; j--) entries[j] = entries[j-1];
              entries[pi-1] = v;
              fill_len++;
              r.status = plid_pkg::ST_OK;
            end
          end
        end
        plid_pkg::OP_DELETE: begin
          if (pi >= 1 && pi <= fill_len) begin
            r.value = entries[pi-1];
            for (int j = pi; j < fill_len; j++) entries[j-1] = entries[j];
            fill_len--;
            r.status = plid_pkg::ST_OK;
          end
        end
        plid_pkg::OP_READ: begin
          if (pi >= 1 && pi <= fill_len) begin
            r.value = entries[pi-1];
            r.status = plid_pkg::ST_OK;
          end
        end
        default: ;
      endcase
      r.count = fill_len[7:0];
      r.empty = (fill_len == 0);
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] val, logic [7:0] cnt, logic emp);
      list_result_t r;
      if (expected_q.size() == 0) begin
        $error("result word with no command waiting: status %0d value %h", st, val);
        error_count++;
        return;
      end
      r = expected_q.pop_front();
      if (st !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, st);
        error_count++;
      end
      if (val !== r.value) begin
        $error("value_out: expected %h, actual %h", r.value, val);
        error_count++;
      end
      if (cnt !== r.count) begin
        $error("count: expected %0d, actual %0d", r.count, cnt);
        error_count++;
      end
      if (emp !== r.empty) begin
        $error("empty_res: expected %0d, actual %0d", r.empty, emp);
        error_count++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flag_missing();
      if (expected_q.size() != 0) begin
        $error("%0d result words never arrived", expected_q.size());
        error_count += expected_q.size();
      end
    endfunction
  endclass

  logic        clk;
  logic        rst      = 1'b1;
  logic        start    = 1'b0;
  logic [1:0]  kind     = plid_pkg::OP_READ;
  logic [7:0]  position = '0;
  logic [31:0] value_in = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [31:0] value_out;
  logic [7:0]  count;
  logic        empty_res;

  list_tracker lst = new();

  positional_list_insert_delete dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .position(position), .value_in(value_in),
    .done(done), .status(status), .value_out(value_out),
    .count(count), .empty_res(empty_res)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) lst.check_result(status, value_out, count, empty_res);
  end

  task automatic send_word(logic [1:0] k, logic [7:0] p, logic [31:0] v);
    start    <= 1'b1;
    kind     <= k;
    position <= p;
    value_in <= v;
    do @(posedge clk); while (busy);
    lst.note_command(k, p, v);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic pick_command(traffic_mode_t mode, output logic [1:0] k,
                              output logic [7:0] p, output logic [31:0] v);
    int r;
    int top;
    r = $urandom_range(99);
    if (r < 3) k = OP_UNUSED;
    else if (r < 18) k = plid_pkg::OP_READ;
    else begin
      r = $urandom_range(99);
      case (mode)
        MODE_FILL:  k = (r < 80) ? plid_pkg::OP_INSERT : plid_pkg::OP_DELETE;
        MODE_DRAIN: k = (r < 80) ? plid_pkg::OP_DELETE : plid_pkg::OP_INSERT;
        default:    k = (r < 50) ? plid_pkg::OP_INSERT : plid_pkg::OP_DELETE;
      endcase
    end
    top = (k == plid_pkg::OP_INSERT) ? lst.fill_len + 1 : lst.fill_len;
    r = $urandom_range(99);
    if (r < 6) p = 8'd0;
    else if (r < 14) p = 8'($urandom_range(255));
    else if (r < 24) p = ($urandom_range(1) == 0 || top == 0) ? 8'd1 : 8'(top);
    else p = (top == 0) ? 8'd1 : 8'($urandom_range(top, 1));
    v = pick_value();
  endtask

  initial begin
    traffic_mode_t mode;
    logic [1:0]  k;
    logic [7:0]  p;
    logic [31:0] v;
    int burst;
    int extremes_left;
    int guard;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_word(plid_pkg::OP_READ,   8'd1,   32'hFFFF_FFFF);
    send_word(plid_pkg::OP_DELETE, 8'd1,   32'h0);
    send_word(plid_pkg::OP_INSERT, 8'd0,   32'h1111_1111);
    send_word(plid_pkg::OP_INSERT, 8'd2,   32'h2222_2222);
    pause(2);
    send_word(plid_pkg::OP_INSERT, 8'd1,   32'hFFFF_FFFF);
    send_word(plid_pkg::OP_INSERT, 8'd2,   32'h0000_0000);
    send_word(plid_pkg::OP_INSERT, 8'd1,   32'h1234_5678);
    send_word(plid_pkg::OP_INSERT, 8'd4,   32'hA5A5_A5A5);
    send_word(plid_pkg::OP_INSERT, 8'd6,   32'h5A5A_5A5A);
    pause(1);
    send_word(plid_pkg::OP_READ,   8'd0,   32'hFFFF_FFFF);
    send_word(plid_pkg::OP_READ,   8'd4,   32'h0);
    send_word(plid_pkg::OP_READ,   8'd5,   32'h0);
    send_word(plid_pkg::OP_READ,   8'd255, 32'h0);
    send_word(OP_UNUSED,           8'd1,   32'hFFFF_FFFF);
    send_word(plid_pkg::OP_DELETE, 8'd2,   32'h0);
    send_word(plid_pkg::OP_DELETE, 8'd3,   32'h0);
    pause(3);
    send_word(plid_pkg::OP_DELETE, 8'd0,   32'h0);
    send_word(plid_pkg::OP_DELETE, 8'd255, 32'h0);
    send_word(plid_pkg::OP_INSERT, 8'd255, 32'hDEAD_BEEF);
    send_word(plid_pkg::OP_READ,   8'd1,   32'h0);
    send_word(plid_pkg::OP_DELETE, 8'd1,   32'h0);
    send_word(plid_pkg::OP_DELETE, 8'd1,   32'h0);
    send_word(plid_pkg::OP_INSERT, 8'd128, 32'hFFFF_FFFF);
    send_word(OP_UNUSED,           8'd0,   32'h0);
    pause($urandom_range(5, 1));

    mode = MODE_FILL;
    extremes_left = -1;
    for (int n = 0; n < 1600; ) begin
      burst = $urandom_range(24, 1);
      for (int b = 0; b < burst && n < 1600; b++, n++) begin
        if ((lst.fill_len == CAP && mode == MODE_FILL) ||
            (lst.fill_len == 0 && mode == MODE_DRAIN)) begin
          if (extremes_left < 0) extremes_left = $urandom_range(12, 3);
          else if (extremes_left == 0) begin
            mode = (mode == MODE_FILL) ? MODE_DRAIN : MODE_FILL;
            extremes_left = -1;
          end else extremes_left--;
        end else if ($urandom_range(199) == 0) begin
          mode = traffic_mode_t'($urandom_range(2));
          extremes_left = -1;
        end
        pick_command(mode, k, p, v);
        send_word(k, p, v);
      end
      if ($urandom_range(3) != 0) pause($urandom_range(8, 1));
    end
    pause(1);

    guard = 0;
    while (lst.pending() > 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    lst.flag_missing();
    if (lst.error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
